// File: hdl/sfpw_pkg.sv
// Shared types and constants of the SPI flash page write sequencer.
package sfpw_pkg;

	localparam int ADDR_W     = 24;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_OPCODE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_ENABLE_OPCODE = 1'd1;

	// reset values of the opcode registers
	localparam logic [BYTE_W-1:0] PROGRAM_OPCODE_RST      = 8'h02;
	localparam logic [BYTE_W-1:0] WRITE_ENABLE_OPCODE_RST = 8'h06;

	// one classified data byte, handed from the front end to the back end
	typedef struct packed {
		logic              open_chunk;  // needs write enable, opcode and address first
		logic              close_chunk; // chip select goes high after the data
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} sfpw_cmd_t;

	// bus word being emitted by the back end
	typedef enum logic [2:0] {
		STEP_WREN,
		STEP_OPCODE,
		STEP_ADDR_HI,
		STEP_ADDR_MID,
		STEP_ADDR_LO,
		STEP_DATA
	} sfpw_step_t;

endpackage

// File: hdl/sfpw_front.sv
// Front end: accepts input words, tracks the flash address and classifies each byte.
module sfpw_front #(
	parameter int PAGE_SIZE = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [7:0]                data_byte,
	input  logic                      first_byte,
	input  logic [23:0]               start_address,
	input  logic                      last_byte,
	input  logic                      q_full,
	output logic                      q_push,
	output sfpw_pkg::sfpw_cmd_t       q_cmd
);
	import sfpw_pkg::*;

	// page size is a power of two; page offset is the low address bits
	localparam int PAGE_BITS = $clog2(PAGE_SIZE);

	logic [ADDR_W-1:0] next_address_q;
	logic              chunk_open_q;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] addr_inc;
	logic              close;

	assign q_push = push & ~q_full;

	// a new request only moves the address when no chunk is open
	assign cur_addr = (!chunk_open_q && first_byte) ? start_address : next_address_q;
	assign addr_inc = cur_addr + ADDR_W'(1);
	assign close    = last_byte | (addr_inc[PAGE_BITS-1:0] == '0);

	always_comb begin
		q_cmd.open_chunk  = ~chunk_open_q;
		q_cmd.close_chunk = close;
		q_cmd.addr        = cur_addr;
		q_cmd.data        = data_byte;
	end

	// address and chunk tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_address_q <= '0;
			chunk_open_q   <= 1'b0;
		end else if (q_push) begin
			next_address_q <= addr_inc;
			chunk_open_q   <= ~close;
		end
	end

endmodule

// File: hdl/sfpw_cmdq.sv
// Short command queue between the front end and the back end.
module sfpw_cmdq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  sfpw_pkg::sfpw_cmd_t wr_cmd,
	input  logic                rd_en,
	output sfpw_pkg::sfpw_cmd_t rd_cmd,
	output logic                full,
	output logic                valid
);
	import sfpw_pkg::*;

	sfpw_cmd_t             entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full   = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign valid  = (count_q != '0);
	assign rd_cmd = entry_q[rd_ptr_q];
	assign do_wr  = wr_en & ~full;
	assign do_rd  = rd_en & valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/sfpw_back.sv
// Back end: expands each command into bus words and holds the output word.
module sfpw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  sfpw_pkg::sfpw_cmd_t cmd,
	output logic                cmd_pop,
	input  logic [7:0]          program_opcode,
	input  logic [7:0]          write_enable_opcode,
	input  logic                pop,
	output logic                empty,
	output logic [7:0]          spi_byte,
	output logic                frame_start,
	output logic                frame_end,
	output logic                wait_ready,
	output logic                last
);
	import sfpw_pkg::*;

	sfpw_step_t        state_q;
	sfpw_step_t        state_nxt;
	sfpw_step_t        cur_step;
	logic              out_valid_q;
	logic              load;
	logic [BYTE_W-1:0] byte_nxt;
	logic              fs_nxt;
	logic              fe_nxt;
	logic              wr_nxt;
	logic              last_nxt;

	// a command inside an open chunk goes straight to its data word
	assign cur_step = cmd.open_chunk ? state_q : STEP_DATA;
	assign load     = cmd_valid & (~out_valid_q | pop);
	assign cmd_pop  = load & (cur_step == STEP_DATA);
	assign empty    = ~out_valid_q;

	// next step
	always_comb begin
		state_nxt = state_q;
		if (load) begin
			case (cur_step)
				STEP_WREN:     state_nxt = STEP_OPCODE;
				STEP_OPCODE:   state_nxt = STEP_ADDR_HI;
				STEP_ADDR_HI:  state_nxt = STEP_ADDR_MID;
				STEP_ADDR_MID: state_nxt = STEP_ADDR_LO;
				STEP_ADDR_LO:  state_nxt = STEP_DATA;
				STEP_DATA:     state_nxt = STEP_WREN;
				default:       state_nxt = STEP_WREN;
			endcase
		end
	end

	// word for the current step
	always_comb begin
		byte_nxt = cmd.data;
		fs_nxt   = 1'b0;
		fe_nxt   = 1'b0;
		wr_nxt   = 1'b0;
		last_nxt = 1'b0;
		case (cur_step)
			STEP_WREN: begin
				byte_nxt = write_enable_opcode;
				fs_nxt   = 1'b1;
				fe_nxt   = 1'b1;
			end
			STEP_OPCODE: begin
				byte_nxt = program_opcode;
				fs_nxt   = 1'b1;
			end
			STEP_ADDR_HI:  byte_nxt = cmd.addr[23:16];
			STEP_ADDR_MID: byte_nxt = cmd.addr[15:8];
			STEP_ADDR_LO:  byte_nxt = cmd.addr[7:0];
			STEP_DATA: begin
				byte_nxt = cmd.data;
				fe_nxt   = cmd.close_chunk;
				wr_nxt   = cmd.close_chunk;
				last_nxt = 1'b1;
			end
			default: byte_nxt = cmd.data;
		endcase
	end

	// step register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STEP_WREN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (load) begin
			spi_byte    <= byte_nxt;
			frame_start <= fs_nxt;
			frame_end   <= fe_nxt;
			wait_ready  <= wr_nxt;
			last        <= last_nxt;
		end
	end

endmodule

// File: hdl/spi_flash_page_write_sequencer_top.sv
// The first bus word of an input word passes the command queue and the output register.
// The back end emits one bus word per cycle while the result side keeps popping; a byte that
// opens a page chunk gives six bus words, a byte inside an open chunk gives one.
// A two-entry command queue lets the front end keep taking words while the back end is busy.
// Reset (arst_n low, asynchronous): address 0, no chunk open, queue and output empty,
// opcodes back to page program 0x02 and write enable 0x06.
module spi_flash_page_write_sequencer_top #(
	parameter int PAGE_SIZE = 256 // power of two, 16 to 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic [23:0] start_address,
	input  logic        last_byte,
	// bus words
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  spi_byte,
	output logic        frame_start,
	output logic        frame_end,
	output logic        wait_ready,
	output logic        last,
	// configuration
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);
	import sfpw_pkg::*;

	logic              q_push;
	logic              q_pop;
	logic              q_valid;
	sfpw_cmd_t         q_wr_cmd;
	sfpw_cmd_t         q_rd_cmd;
	logic [BYTE_W-1:0] program_opcode_q;
	logic [BYTE_W-1:0] write_enable_opcode_q;

	// opcode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_opcode_q      <= PROGRAM_OPCODE_RST;
			write_enable_opcode_q <= WRITE_ENABLE_OPCODE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PROGRAM_OPCODE:      program_opcode_q      <= cfg_wdata;
				REG_WRITE_ENABLE_OPCODE: write_enable_opcode_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	sfpw_front #(
		.PAGE_SIZE (PAGE_SIZE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.start_address (start_address),
		.last_byte     (last_byte),
		.q_full        (full),
		.q_push        (q_push),
		.q_cmd         (q_wr_cmd)
	);

	sfpw_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_cmd (q_wr_cmd),
		.rd_en  (q_pop),
		.rd_cmd (q_rd_cmd),
		.full   (full),
		.valid  (q_valid)
	);

	sfpw_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd_valid           (q_valid),
		.cmd                 (q_rd_cmd),
		.cmd_pop             (q_pop),
		.program_opcode      (program_opcode_q),
		.write_enable_opcode (write_enable_opcode_q),
		.pop                 (pop),
		.empty               (empty),
		.spi_byte            (spi_byte),
		.frame_start         (frame_start),
		.frame_end           (frame_end),
		.wait_ready          (wait_ready),
		.last                (last)
	);

endmodule

// File: hdl/sfpw_checker.sv
// Port-level checks of the sequencer's bus word stream, bound to the top level.
module sfpw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  spi_byte,
	input logic        frame_start,
	input logic        frame_end,
	input logic        wait_ready,
	input logic        last
);

	// a waiting word holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(spi_byte) && $stable(last))
		else $error("bus word changed while waiting");

	// polling is only asked for at the end of a data word
	a_wait_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && wait_ready |-> frame_end && last && !frame_start)
		else $error("wait_ready outside a closing data word");

	// frame-opening words never end an input word's results
	a_start_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_start |-> !last)
		else $error("frame start flagged as last word");

	// the write-enable frame needs no polling
	a_wren_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_start && frame_end |-> !wait_ready)
		else $error("write enable frame flagged for polling");

endmodule

bind spi_flash_page_write_sequencer_top sfpw_checker u_sfpw_checker (.*);

// File: bench/spi_flash_page_write_sequencer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the SPI flash page write sequencer, with a page-split predictor.
module spi_flash_page_write_sequencer_top_tb;
	import sfpw_pkg::*;

	localparam int PAGE         = 256;
	localparam int PAGE_BITS    = $clog2(PAGE);
	localparam int CLK_HALF     = 5;
	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_WORDS  = 36;
	localparam int N_DIR        = 18;

	// one input word
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic [23:0] addr;
		logic        lastb;
	} flash_word_t;

	// one bus word on the result side
	typedef struct packed {
		logic [7:0] spi_byte;
		logic       frame_start;
		logic       frame_end;
		logic       wait_ready;
		logic       last;
	} bus_word_t;

	// directed row: input fields, then the typed-in expectation where there is one
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic [23:0] addr;
		logic        lastb;
		logic        typed;
		logic        opens;
		logic [23:0] at;
		logic        closes;
	} dir_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        push          = 1'b0;
	logic        full;
	logic [7:0]  data_byte     = '0;
	logic        first_byte    = 1'b0;
	logic [23:0] start_address = '0;
	logic        last_byte     = 1'b0;
	logic        empty;
	logic        pop           = 1'b0;
	logic [7:0]  spi_byte;
	logic        frame_start;
	logic        frame_end;
	logic        wait_ready;
	logic        last;
	logic        cfg_write     = 1'b0;
	logic [0:0]  cfg_index     = '0;
	logic [7:0]  cfg_wdata     = '0;

	// predictor state and configuration copy
	logic [7:0]  prog_op;
	logic [7:0]  wren_op;
	logic [23:0] next_addr;
	logic        chunk_open;

	bus_word_t   split_words [$];
	bus_word_t   bus_words_due [$];
	int          mismatches = 0;
	int          words_fed  = 0;
	bit          steady     = 1'b0;

	//          data   first addr        lastb typed opens at          closes
	dir_row_t dir_rows [N_DIR] = '{
		{8'h00, 1'b0, 24'hABCDEF, 1'b0, 1'b1, 1'b1, 24'h000000, 1'b0}, // no request after reset
		{8'hFF, 1'b1, 24'h123456, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b1}, // first inside open chunk
		{8'hA5, 1'b1, 24'hFFFFFE, 1'b0, 1'b1, 1'b1, 24'hFFFFFE, 1'b0},
		{8'h5A, 1'b0, 24'h000000, 1'b0, 1'b1, 1'b0, 24'h000000, 1'b1}, // wraps to 0
		{8'h3C, 1'b0, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 24'h000000, 1'b1},
		{8'hC3, 1'b1, 24'h0000FE, 1'b0, 1'b1, 1'b1, 24'h0000FE, 1'b0},
		{8'h0F, 1'b0, 24'h555555, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b1}, // ends on page edge
		{8'hF0, 1'b0, 24'hAAAAAA, 1'b0, 1'b1, 1'b1, 24'h000100, 1'b0},
		{8'h80, 1'b1, 24'hFFFFFF, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b1},
		{8'h01, 1'b1, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, 1'b1},
		{8'h7F, 1'b1, 24'h800000, 1'b0, 1'b1, 1'b1, 24'h800000, 1'b0},
		{8'hFE, 1'b0, 24'h7FFFFF, 1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
		{8'h55, 1'b0, 24'h000001, 1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
		{8'hAA, 1'b1, 24'h0000F0, 1'b1, 1'b0, 1'b0, 24'h000000, 1'b0},
		{8'h11, 1'b1, 24'h0123FD, 1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
		{8'h22, 1'b0, 24'h3C3C3C, 1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
		{8'h33, 1'b0, 24'hC3C3C3, 1'b0, 1'b0, 1'b0, 24'h000000, 1'b0}, // crosses a page
		{8'h44, 1'b0, 24'h000000, 1'b1, 1'b0, 1'b0, 24'h000000, 1'b0}
	};

	spi_flash_page_write_sequencer_top #(
		.PAGE_SIZE(PAGE)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.start_address(start_address),
		.last_byte    (last_byte),
		.empty        (empty),
		.pop          (pop),
		.spi_byte     (spi_byte),
		.frame_start  (frame_start),
		.frame_end    (frame_end),
		.wait_ready   (wait_ready),
		.last         (last),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog
	initial begin : watchdog
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic bus_word_t bw(logic [7:0] b, logic fs, logic fe, logic wr, logic l);
		bus_word_t w;
		w.spi_byte    = b;
		w.frame_start = fs;
		w.frame_end   = fe;
		w.wait_ready  = wr;
		w.last        = l;
		return w;
	endfunction

	// header words of a fresh page chunk: write enable frame, opcode, address big-endian
	task automatic push_chunk_header(input logic [23:0] a);
		split_words.push_back(bw(wren_op, 1'b1, 1'b1, 1'b0, 1'b0));
		split_words.push_back(bw(prog_op, 1'b1, 1'b0, 1'b0, 1'b0));
		split_words.push_back(bw(a[23:16], 1'b0, 1'b0, 1'b0, 1'b0));
		split_words.push_back(bw(a[15:8], 1'b0, 1'b0, 1'b0, 1'b0));
		split_words.push_back(bw(a[7:0], 1'b0, 1'b0, 1'b0, 1'b0));
	endtask

	// predictor: bus words caused by one input word, left in split_words
	task automatic split_at_pages(input flash_word_t w);
		logic closes;
		split_words.delete();
		if (!chunk_open) begin
			if (w.first)
				next_addr = w.addr;
			push_chunk_header(next_addr);
			chunk_open = 1'b1;
		end
		next_addr = next_addr + 24'd1;
		closes = w.lastb || (next_addr[PAGE_BITS-1:0] == '0);
		split_words.push_back(bw(w.data, 1'b0, closes, closes, 1'b1));
		if (closes)
			chunk_open = 1'b0;
	endtask

	// hand one word to the block, after a random gap unless steady; push is left high
	task automatic send_word(input flash_word_t w);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push          <= 1'b1;
		data_byte     <= w.data;
		first_byte    <= w.first;
		start_address <= w.addr;
		last_byte     <= w.lastb;
		do @(posedge clk); while (full !== 1'b0);
		words_fed++;
	endtask

	task automatic feed(input flash_word_t w);
		send_word(w);
		split_at_pages(w);
		foreach (split_words[i])
			bus_words_due.push_back(split_words[i]);
	endtask

	// stop sending and let every expected bus word come out
	task automatic drain_out();
		push <= 1'b0;
		while (bus_words_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_opcodes(input logic [7:0] p, input logic [7:0] we);
		cfg_write <= 1'b1;
		cfg_index <= REG_PROGRAM_OPCODE;
		cfg_wdata <= p;
		@(posedge clk);
		prog_op = p;
		cfg_index <= REG_WRITE_ENABLE_OPCODE;
		cfg_wdata <= we;
		@(posedge clk);
		wren_op = we;
		cfg_write <= 1'b0;
	endtask

	// one random request: mostly well formed, some stray or broken
	task automatic send_request();
		flash_word_t w;
		int kind;
		int len;
		logic [23:0] base;
		kind = $urandom_range(0, 9);
		base = 24'($urandom_range(0, 24'hFFFFFF));
		case ($urandom_range(0, 3))
			1: base[7:0] = 8'(8'hFF - $urandom_range(0, 7));
			2: base = 24'(24'hFFFFFF - $urandom_range(0, 15));
			3: base[7:0] = 8'h00;
			default: ;
		endcase
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		if (kind == 7) begin
			// stray byte with no request
			w.data  = 8'($urandom_range(0, 255));
			w.first = 1'b0;
			w.addr  = 24'($urandom_range(0, 24'hFFFFFF));
			w.lastb = 1'($urandom_range(0, 1));
			feed(w);
		end else begin
			for (int i = 0; i < len; i++) begin
				w.data  = 8'($urandom_range(0, 255));
				w.addr  = (i == 0) ? base : 24'($urandom_range(0, 24'hFFFFFF));
				w.first = (i == 0) || (kind == 9 && i == len / 2);
				// kind 8 never closes its request
				w.lastb = (i == len - 1) && (kind != 8);
				feed(w);
			end
		end
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// result side: random stalls unless steady, compare each bus word with the oldest expectation
	initial begin : drain
		int stall;
		bus_word_t want;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			if (bus_words_due.size() == 0) begin
				$error("bus word %0h with nothing expected", spi_byte);
				mismatches++;
			end else begin
				want = bus_words_due.pop_front();
				check_field("spi_byte", want.spi_byte, spi_byte);
				check_field("frame_start", 8'(want.frame_start), 8'(frame_start));
				check_field("frame_end", 8'(want.frame_end), 8'(frame_end));
				check_field("wait_ready", 8'(want.wait_ready), 8'(wait_ready));
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	// stimulus
	initial begin : stimulus
		flash_word_t w;
		dir_row_t r;
		int target;
		prog_op    = PROGRAM_OPCODE_RST;
		wren_op    = WRITE_ENABLE_OPCODE_RST;
		next_addr  = '0;
		chunk_open = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset opcodes
		for (int i = 0; i < N_DIR; i++) begin
			r = dir_rows[i];
			w.data  = r.data;
			w.first = r.first;
			w.addr  = r.addr;
			w.lastb = r.lastb;
			send_word(w);
			split_at_pages(w);
			if (r.typed) begin
				split_words.delete();
				if (r.opens)
					push_chunk_header(r.at);
				split_words.push_back(bw(r.data, 1'b0, r.closes, r.closes, 1'b1));
			end
			foreach (split_words[j])
				bus_words_due.push_back(split_words[j]);
		end
		drain_out();

		// random phases, one opcode setting each; idle between them
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_opcodes(8'h00, 8'h00);
				1: write_opcodes(8'hFF, 8'hFF);
				3: write_opcodes(8'h00, 8'hFF);
				default: write_opcodes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			steady = (phase == 2);
			target = words_fed + PHASE_WORDS;
			while (words_fed < target)
				send_request();
			drain_out();
		end
		steady = 1'b0;

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
